// ===== rtl/core/modbus_rtu_slave_responder_core_macros.svh =====
// Assertion macros for the Modbus RTU slave responder checker.
// Used by mrs_checker.sv only; no other dependencies.
`ifndef MODBUS_RTU_SLAVE_RESPONDER_CORE_MACROS_SVH
`define MODBUS_RTU_SLAVE_RESPONDER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define MRS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define MRS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/mrs_pkg.sv =====
// Shared types, constants and functions of the Modbus RTU slave responder.
// No dependencies; used by every module of the block but the bound checker.
`timescale 1ns / 1ps
package mrs_pkg;

  localparam int RX_DEPTH   = 64;
  localparam int RX_AW      = $clog2(RX_DEPTH);
  localparam int FRAME_MAX  = 17;
  localparam int FRAME_SHORT = 8;
  localparam int MAX_OUT    = 64;
  localparam int MAX_RESP   = 25;
  localparam int SCAN_LIMIT = MAX_OUT - MAX_RESP;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [7:0]  FC_READ  = 8'd3;
  localparam logic [7:0]  FC_WRITE = 8'd6;
  localparam logic [7:0]  FC_WRMULTI = 8'h10;
  localparam logic [7:0]  BCAST_ADDR = 8'd0;
  localparam logic [7:0]  SERIAL_BYTES = 8'd8;
  localparam logic [15:0] REG_ADDR   = 16'h0000;
  localparam logic [15:0] REG_BAUD   = 16'h0001;
  localparam logic [15:0] REG_PCOEF  = 16'h0008;
  localparam logic [15:0] REG_TCOEF  = 16'h0009;
  localparam logic [15:0] REG_CCOEF  = 16'h0030;
  localparam logic [15:0] REG_SERIAL = 16'h0040;
  localparam logic [15:0] COEF_MIN   = 16'd7000;
  localparam logic [15:0] COEF_MAX   = 16'd13000;
  localparam logic [2:0]  BAUD_DEFAULT = 3'd3;
  localparam logic [2:0]  BAUD_MIN = 3'd1;
  localparam logic [2:0]  BAUD_MAX = 3'd4;
  localparam logic [31:0] DIV100_MAGIC = 32'd1374389535;

  typedef enum logic {ITEM_BYTE = 1'b0, ITEM_MEAS = 1'b1} item_kind_e;

  typedef enum logic [1:0] {
    MEAS_PRESS = 2'd0, MEAS_TEMP = 2'd1, MEAS_BATT = 2'd2, MEAS_LOOP = 2'd3
  } meas_e;

  typedef enum logic [3:0] {
    CFG_SLAVE_ADDR = 4'd0, CFG_BAUD = 4'd1, CFG_DECIMAL = 4'd2, CFG_UNIT = 4'd3,
    CFG_FULL_SCALE = 4'd4, CFG_PCOEF = 4'd5, CFG_TCOEF = 4'd6, CFG_CCOEF = 4'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_POP, ST_CHECK, ST_LD_ADDR, ST_LD_DATA, ST_DECIDE, ST_EMIT, ST_CRC_LO, ST_CRC_HI
  } state_e;

  typedef enum logic [1:0] {DEC_WAIT, DEC_DROP, DEC_ACCEPT} dec_e;

  typedef enum logic [1:0] {RSP_SERIAL, RSP_REGS, RSP_ECHO} rsp_e;

  typedef struct packed {
    item_kind_e  kind;
    logic [7:0]  rx_byte;
    meas_e       midx;
    logic [31:0] mval;
  } item_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [RX_AW-1:0] rx_wrap(input logic [RX_AW:0] a,
                                               input logic [RX_AW:0] b);
    logic [RX_AW+1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (RX_AW+2)'(RX_DEPTH)) begin
      s = s - (RX_AW+2)'(RX_DEPTH);
    end
    return s[RX_AW-1:0];
  endfunction

endpackage

// ===== rtl/core/modbus_rtu_slave_responder_core.sv =====
// Flow: a received byte passes the front-end queue, is written to the buffer in ST_POP and
// is then scanned; each frame attempt loads up to 17 buffered bytes, each by ST_LD_ADDR and
// ST_LD_DATA (one memory read port), then decides. Response bytes go out one per cycle while
// the output is taken; dropped bytes each cost an attempt; no item is popped during a scan.
// Reset: asynchronous, buffer empty, state from register reset values; no clearing pass.
// Top level of the Modbus RTU slave responder; uses mrs_pkg, mrs_front, mrs_back.
`timescale 1ns / 1ps
module modbus_rtu_slave_responder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // rx_byte[7:0], measure_index[9:8], measure_value[41:10]
  input  logic        s_axis_tuser,   // kind[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // tx_byte[7:0], new_baud_code[10:8]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // baud_changed[0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  mrs_pkg::item_t item;
  logic           item_valid, item_pop;

  mrs_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .item_valid_o(item_valid), .item_o(item), .item_pop_i(item_pop)
  );

  mrs_back u_back (
    .clk_i, .rst_ni,
    .item_valid_i(item_valid), .item_i(item), .item_pop_o(item_pop),
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

endmodule

// ===== rtl/core/mrs_div100.sv =====
// Signed divide-by-100 unit, truncating toward zero, low 16 bits out.
// Three register stages, reciprocal multiply; uses mrs_pkg.
`timescale 1ns / 1ps
module mrs_div100 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] value_i,
  output logic [15:0] quot_o
);

  logic        neg_q, neg2_q;
  logic [31:0] abs_q;
  logic [63:0] prod_q;
  logic [15:0] quot_q;
  logic [15:0] q_lo;

  assign q_lo   = prod_q[52:37];
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q  <= 1'b0;
      neg2_q <= 1'b0;
      abs_q  <= '0;
      prod_q <= '0;
      quot_q <= '0;
    end else begin
      neg_q  <= value_i[31];
      abs_q  <= value_i[31] ? (~value_i + 32'd1) : value_i;
      neg2_q <= neg_q;
      prod_q <= {32'd0, abs_q} * {32'd0, mrs_pkg::DIV100_MAGIC};
      quot_q <= neg2_q ? (~q_lo + 16'd1) : q_lo;
    end
  end

endmodule

// ===== rtl/core/mrs_front.sv =====
// Front end: accepts stream items, classifies them and queues them.
// Two-entry queue toward the back end; uses mrs_pkg.
`timescale 1ns / 1ps
module mrs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [47:0]    s_axis_tdata,
  input  logic           s_axis_tuser,
  output logic           item_valid_o,
  output mrs_pkg::item_t item_o,
  input  logic           item_pop_i
);

  mrs_pkg::item_t q_mem [2];
  mrs_pkg::item_t in_item;
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  always_comb begin
    in_item.kind    = s_axis_tuser ? mrs_pkg::ITEM_MEAS : mrs_pkg::ITEM_BYTE;
    in_item.rx_byte = s_axis_tdata[7:0];
    in_item.midx    = mrs_pkg::meas_e'(s_axis_tdata[9:8]);
    in_item.mval    = s_axis_tdata[41:10];
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_valid_o  = (cnt_q != 2'd0);
  assign pop           = item_pop_i && item_valid_o;
  assign item_o        = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/core/mrs_back.sv =====
// Back end: receive buffer, frame scan with CRC check, response streaming.
// Uses mrs_pkg and mrs_div100.
`timescale 1ns / 1ps
module mrs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  mrs_pkg::item_t item_i,
  output logic           item_pop_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [3:0]     cfg_index_i,
  input  logic [31:0]    cfg_data_i,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [15:0]    m_axis_tdata,
  output logic           m_axis_tlast,
  output logic           m_axis_tuser
);

  localparam int AW = mrs_pkg::RX_AW;

  mrs_pkg::state_e st_q, st_d;
  logic [7:0]    rx_mem [mrs_pkg::RX_DEPTH];
  logic [7:0]    rd_q;
  logic [AW-1:0] head_q;
  logic [AW:0]   cnt_q;
  logic [4:0]    ld_idx_q;
  logic [7:0]    fb_q [mrs_pkg::FRAME_MAX];
  logic [15:0]   crc_q, crc6_q, crc15_q, ocrc_q;
  logic [6:0]    n_q;
  logic [4:0]    k_q, blen_q, flen_q;
  mrs_pkg::rsp_e rsp_q;
  logic          bflag_q;

  logic          out_valid_q, out_last_q, out_bflag_q;
  logic [7:0]    out_byte_q;
  logic [2:0]    out_baud_q;

  logic [7:0]    sa_q, dec_pt_q, unit_q;
  logic [2:0]    baud_q;
  logic [31:0]   fs_q, press_q;
  logic [15:0]   pcoef_q, tcoef_q, ccoef_q, temp_q, loop_q;
  logic [7:0]    batt_q;
  logic [63:0]   serial_q;
  logic [15:0]   p100, fs100;

  logic [4:0]    ld_total;
  logic          ld_last;
  logic [15:0]   crc_nx;
  logic [15:0]   reg_w, num_w, reg_sel, word;
  logic [16:0]   span;
  mrs_pkg::dec_e dec;
  mrs_pkg::rsp_e dec_rsp;
  logic [4:0]    dec_blen, dec_flen;
  logic          emit_fire, out_free;
  logic [7:0]    body_byte, emit_byte;
  logic [4:0]    k_m3;
  logic [63:0]   ser_sh;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [2:0]    cfg_baud;

  mrs_div100 u_div_press (.clk_i, .rst_ni, .value_i(press_q), .quot_o(p100));
  mrs_div100 u_div_fs    (.clk_i, .rst_ni, .value_i(fs_q),    .quot_o(fs100));

  assign cfg_ready_o = 1'b1;
  assign cfg_baud = (cfg_data_i[2:0] >= mrs_pkg::BAUD_MIN && cfg_data_i[2:0] <= mrs_pkg::BAUD_MAX)
                    ? cfg_data_i[2:0] : mrs_pkg::BAUD_DEFAULT;

  assign ld_total = (cnt_q >= (AW+1)'(mrs_pkg::FRAME_MAX)) ? 5'(mrs_pkg::FRAME_MAX)
                                                           : 5'(cnt_q);
  assign ld_last  = (ld_idx_q + 5'd1 == ld_total);
  assign crc_nx   = mrs_pkg::crc_byte(crc_q, rd_q);
  assign wr_addr  = mrs_pkg::rx_wrap({1'b0, head_q}, cnt_q);
  assign rd_addr  = mrs_pkg::rx_wrap({1'b0, head_q}, (AW+1)'(ld_idx_q));
  assign reg_w    = {fb_q[2], fb_q[3]};
  assign num_w    = {fb_q[4], fb_q[5]};
  assign span     = {1'b0, reg_w} + {1'b0, num_w};
  assign out_free = !out_valid_q || m_axis_tready;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      mrs_pkg::ST_POP:     if (item_valid_i) st_d = mrs_pkg::ST_CHECK;
      mrs_pkg::ST_CHECK: begin
        if (n_q > 7'(mrs_pkg::SCAN_LIMIT) || cnt_q < (AW+1)'(2)) st_d = mrs_pkg::ST_POP;
        else st_d = mrs_pkg::ST_LD_ADDR;
      end
      mrs_pkg::ST_LD_ADDR: st_d = mrs_pkg::ST_LD_DATA;
      mrs_pkg::ST_LD_DATA: st_d = ld_last ? mrs_pkg::ST_DECIDE : mrs_pkg::ST_LD_ADDR;
      mrs_pkg::ST_DECIDE: begin
        case (dec)
          mrs_pkg::DEC_WAIT:   st_d = mrs_pkg::ST_POP;
          mrs_pkg::DEC_DROP:   st_d = mrs_pkg::ST_CHECK;
          mrs_pkg::DEC_ACCEPT: st_d = mrs_pkg::ST_EMIT;
          default:             st_d = mrs_pkg::ST_POP;
        endcase
      end
      mrs_pkg::ST_EMIT:   if (out_free && k_q + 5'd1 == blen_q) st_d = mrs_pkg::ST_CRC_LO;
      mrs_pkg::ST_CRC_LO: if (out_free) st_d = mrs_pkg::ST_CRC_HI;
      mrs_pkg::ST_CRC_HI: if (out_free) st_d = mrs_pkg::ST_CHECK;
      default:            st_d = mrs_pkg::ST_POP;
    endcase
  end

  // decode, response bytes, handshakes
  always_comb begin
    dec      = mrs_pkg::DEC_DROP;
    dec_rsp  = mrs_pkg::RSP_ECHO;
    dec_blen = 5'd6;
    dec_flen = 5'(mrs_pkg::FRAME_SHORT);
    if (!(fb_q[0] == sa_q || fb_q[0] == mrs_pkg::BCAST_ADDR) ||
        !(fb_q[1] == mrs_pkg::FC_READ || fb_q[1] == mrs_pkg::FC_WRITE ||
          fb_q[1] == mrs_pkg::FC_WRMULTI)) begin
      dec = mrs_pkg::DEC_DROP;
    end else if (cnt_q < (AW+1)'(mrs_pkg::FRAME_SHORT)) begin
      dec = mrs_pkg::DEC_WAIT;
    end else if (fb_q[1] == mrs_pkg::FC_WRMULTI) begin
      dec_flen = 5'(mrs_pkg::FRAME_MAX);
      if (fb_q[6] != mrs_pkg::SERIAL_BYTES) dec = mrs_pkg::DEC_DROP;
      else if (cnt_q < (AW+1)'(mrs_pkg::FRAME_MAX)) dec = mrs_pkg::DEC_WAIT;
      else if ({fb_q[16], fb_q[15]} != crc15_q) dec = mrs_pkg::DEC_DROP;
      else dec = mrs_pkg::DEC_ACCEPT;
    end else if ({fb_q[7], fb_q[6]} != crc6_q) begin
      dec = mrs_pkg::DEC_DROP;
    end else if (fb_q[1] == mrs_pkg::FC_READ) begin
      if (reg_w == mrs_pkg::REG_SERIAL) begin
        dec      = mrs_pkg::DEC_ACCEPT;
        dec_rsp  = mrs_pkg::RSP_SERIAL;
        dec_blen = 5'd11;
      end else if ((reg_w < 16'd10 && span < 17'd11) ||
                   (reg_w >= 16'h30 && reg_w < 16'h32 && span < 17'h33)) begin
        dec      = mrs_pkg::DEC_ACCEPT;
        dec_rsp  = mrs_pkg::RSP_REGS;
        dec_blen = 5'd3 + {num_w[3:0], 1'b0};
      end
    end else if (reg_w == mrs_pkg::REG_ADDR || reg_w == mrs_pkg::REG_BAUD ||
                 reg_w == mrs_pkg::REG_PCOEF || reg_w == mrs_pkg::REG_TCOEF ||
                 reg_w == mrs_pkg::REG_CCOEF) begin
      dec = mrs_pkg::DEC_ACCEPT;
    end

    k_m3    = k_q - 5'd3;
    ser_sh  = serial_q << {k_m3[2:0], 3'b000};
    reg_sel = reg_w + {12'd0, k_m3[4:1]};
    case (reg_sel)
      16'd0:   word = {8'd0, sa_q};
      16'd1:   word = {13'd0, baud_q};
      16'd2:   word = {8'd0, dec_pt_q - 8'd2};
      16'd3:   word = {8'd0, unit_q};
      16'd4:   word = p100;
      16'd5:   word = fs100;
      16'd6:   word = temp_q;
      16'd7:   word = {8'd0, batt_q};
      16'd8:   word = pcoef_q;
      16'd9:   word = tcoef_q;
      16'h30:  word = ccoef_q;
      default: word = loop_q;
    endcase

    if (k_q == 5'd0) begin
      body_byte = sa_q;
    end else if (k_q == 5'd1) begin
      body_byte = (rsp_q == mrs_pkg::RSP_ECHO) ? fb_q[1] : mrs_pkg::FC_READ;
    end else begin
      case (rsp_q)
        mrs_pkg::RSP_SERIAL:
          body_byte = (k_q == 5'd2) ? mrs_pkg::SERIAL_BYTES : ser_sh[63:56];
        mrs_pkg::RSP_REGS:
          body_byte = (k_q == 5'd2) ? {num_w[6:0], 1'b0}
                                    : (k_m3[0] ? word[7:0] : word[15:8]);
        default:
          body_byte = fb_q[k_q];
      endcase
    end

    case (st_q)
      mrs_pkg::ST_CRC_LO: emit_byte = ocrc_q[7:0];
      mrs_pkg::ST_CRC_HI: emit_byte = ocrc_q[15:8];
      default:            emit_byte = body_byte;
    endcase

    emit_fire  = out_free && (st_q == mrs_pkg::ST_EMIT || st_q == mrs_pkg::ST_CRC_LO ||
                              st_q == mrs_pkg::ST_CRC_HI);
    item_pop_o = (st_q == mrs_pkg::ST_POP);
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_baud_q, out_byte_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_bflag_q;

  always_ff @(posedge clk_i) begin
    if (st_q == mrs_pkg::ST_POP && item_valid_i && item_i.kind == mrs_pkg::ITEM_BYTE &&
        cnt_q < (AW+1)'(mrs_pkg::RX_DEPTH)) begin
      rx_mem[wr_addr] <= item_i.rx_byte;
    end
    rd_q <= rx_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (st_q == mrs_pkg::ST_LD_DATA) begin
      fb_q[ld_idx_q] <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= mrs_pkg::ST_POP;
      head_q      <= '0;
      cnt_q       <= '0;
      ld_idx_q    <= '0;
      crc_q       <= mrs_pkg::CRC_INIT;
      crc6_q      <= '0;
      crc15_q     <= '0;
      ocrc_q      <= mrs_pkg::CRC_INIT;
      n_q         <= '0;
      k_q         <= '0;
      blen_q      <= '0;
      flen_q      <= '0;
      rsp_q       <= mrs_pkg::RSP_ECHO;
      bflag_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_bflag_q <= 1'b0;
      out_byte_q  <= '0;
      out_baud_q  <= '0;
      sa_q        <= 8'd1;
      baud_q      <= mrs_pkg::BAUD_DEFAULT;
      dec_pt_q    <= 8'd2;
      unit_q      <= '0;
      fs_q        <= '0;
      pcoef_q     <= 16'd10000;
      tcoef_q     <= 16'd10000;
      ccoef_q     <= 16'd10000;
      serial_q    <= '0;
      press_q     <= '0;
      temp_q      <= '0;
      batt_q      <= '0;
      loop_q      <= '0;
    end else begin
      st_q <= st_d;

      if (cfg_valid_i) begin
        case (mrs_pkg::cfg_idx_e'(cfg_index_i))
          mrs_pkg::CFG_SLAVE_ADDR: sa_q     <= cfg_data_i[7:0];
          mrs_pkg::CFG_BAUD:       baud_q   <= cfg_baud;
          mrs_pkg::CFG_DECIMAL:    dec_pt_q <= cfg_data_i[7:0];
          mrs_pkg::CFG_UNIT:       unit_q   <= cfg_data_i[7:0];
          mrs_pkg::CFG_FULL_SCALE: fs_q     <= cfg_data_i;
          mrs_pkg::CFG_PCOEF:      pcoef_q  <= cfg_data_i[15:0];
          mrs_pkg::CFG_TCOEF:      tcoef_q  <= cfg_data_i[15:0];
          mrs_pkg::CFG_CCOEF:      ccoef_q  <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      if (emit_fire) begin
        out_valid_q <= 1'b1;
        out_byte_q  <= emit_byte;
        out_last_q  <= (st_q == mrs_pkg::ST_CRC_HI);
        out_bflag_q <= bflag_q;
        out_baud_q  <= baud_q;
        n_q         <= n_q + 7'd1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (st_q)
        mrs_pkg::ST_POP: begin
          if (item_valid_i) begin
            n_q <= '0;
            if (item_i.kind == mrs_pkg::ITEM_BYTE) begin
              if (cnt_q < (AW+1)'(mrs_pkg::RX_DEPTH)) cnt_q <= cnt_q + (AW+1)'(1);
            end else begin
              case (item_i.midx)
                mrs_pkg::MEAS_PRESS: press_q <= item_i.mval;
                mrs_pkg::MEAS_TEMP:  temp_q  <= item_i.mval[15:0];
                mrs_pkg::MEAS_BATT:  batt_q  <= item_i.mval[7:0];
                default:             loop_q  <= item_i.mval[15:0];
              endcase
            end
          end
        end
        mrs_pkg::ST_CHECK: begin
          ld_idx_q <= '0;
          crc_q    <= mrs_pkg::CRC_INIT;
        end
        mrs_pkg::ST_LD_DATA: begin
          crc_q    <= crc_nx;
          ld_idx_q <= ld_idx_q + 5'd1;
          if (ld_idx_q == 5'd5)  crc6_q  <= crc_nx;
          if (ld_idx_q == 5'd14) crc15_q <= crc_nx;
        end
        mrs_pkg::ST_DECIDE: begin
          k_q     <= '0;
          ocrc_q  <= mrs_pkg::CRC_INIT;
          rsp_q   <= dec_rsp;
          blen_q  <= dec_blen;
          flen_q  <= dec_flen;
          bflag_q <= 1'b0;
          if (dec == mrs_pkg::DEC_DROP) begin
            head_q <= mrs_pkg::rx_wrap({1'b0, head_q}, (AW+1)'(1));
            cnt_q  <= cnt_q - (AW+1)'(1);
          end
          if (dec == mrs_pkg::DEC_ACCEPT) begin
            if (fb_q[1] == mrs_pkg::FC_WRMULTI) begin
              serial_q <= {fb_q[7], fb_q[8], fb_q[9], fb_q[10],
                           fb_q[11], fb_q[12], fb_q[13], fb_q[14]};
            end else if (fb_q[1] == mrs_pkg::FC_WRITE) begin
              if (reg_w == mrs_pkg::REG_ADDR) begin
                sa_q <= fb_q[5];
              end else if (reg_w == mrs_pkg::REG_BAUD) begin
                if (fb_q[5] >= 8'(mrs_pkg::BAUD_MIN) && fb_q[5] <= 8'(mrs_pkg::BAUD_MAX)) begin
                  baud_q  <= fb_q[5][2:0];
                  bflag_q <= 1'b1;
                end
              end else if (num_w >= mrs_pkg::COEF_MIN && num_w <= mrs_pkg::COEF_MAX) begin
                if (reg_w == mrs_pkg::REG_PCOEF) pcoef_q <= num_w;
                else if (reg_w == mrs_pkg::REG_TCOEF) tcoef_q <= num_w;
                else ccoef_q <= num_w;
              end
            end
          end
        end
        mrs_pkg::ST_EMIT: begin
          if (out_free) begin
            k_q    <= k_q + 5'd1;
            ocrc_q <= mrs_pkg::crc_byte(ocrc_q, body_byte);
          end
        end
        mrs_pkg::ST_CRC_HI: begin
          if (out_free) begin
            head_q <= mrs_pkg::rx_wrap({1'b0, head_q}, (AW+1)'(flen_q));
            cnt_q  <= cnt_q - (AW+1)'(flen_q);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/mrs_checker.sv =====
// Port-level checker for the Modbus RTU slave responder, bound to the top level.
// Depends on modbus_rtu_slave_responder_core_macros.svh.
`timescale 1ns / 1ps
`include "modbus_rtu_slave_responder_core_macros.svh"
module mrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [3:0]  cfg_index_i,
  input logic [31:0] cfg_data_i
);

  `MRS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `MRS_ASSERT_IMP(a_baud_range, clk_i, rst_ni, m_axis_tvalid, (m_axis_tdata[10:8] == 3'd1) || (m_axis_tdata[10:8] == 3'd2) || (m_axis_tdata[10:8] == 3'd3) || (m_axis_tdata[10:8] == 3'd4))
  `MRS_ASSERT_IMP(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[15:11] == 5'd0)

endmodule

bind modbus_rtu_slave_responder_core mrs_checker u_mrs_checker (.*);

// ===== bench/modbus_rtu_slave_responder_core_chk.sv =====
// Checker for the Modbus RTU slave responder core: watches the input, output and
// config channels, predicts each response byte and compares it. Depends on mrs_pkg.
`timescale 1ns / 1ps
module modbus_rtu_slave_responder_core_chk
  import mrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic [7:0] tx;
    logic       last;
    logic       bchg;
    logic [2:0] baud;
  } tx_beat_t;

  tx_beat_t    resp_q[$];
  logic [7:0]  rx_q[$];
  logic [7:0]  addr_r, dec_r, unit_r;
  logic [2:0]  baud_r;
  logic [31:0] fscale_r, press_r;
  logic [15:0] pcoef_r, tcoef_r, ccoef_r, temp_r, loop_r;
  logic [7:0]  batt_r;
  logic [63:0] serial_r;

  assign pending_o = resp_q.size();

  function automatic logic [15:0] frame_crc(input logic [7:0] q[$], input int n);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < n; i++) begin
      c = c ^ {8'h00, q[i]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [2:0] baud_load(input logic [2:0] v);
    return (v >= BAUD_MIN && v <= BAUD_MAX) ? v : BAUD_DEFAULT;
  endfunction

  function automatic logic [15:0] scaled(input logic [31:0] v);
    logic signed [31:0] s;
    s = $signed(v) / 100;
    return s[15:0];
  endfunction

  function automatic logic [15:0] reg_value(input int r);
    case (r)
      0: return {8'h00, addr_r};
      1: return {13'h0, baud_r};
      2: return {8'h00, dec_r - 8'd2};
      3: return {8'h00, unit_r};
      4: return scaled(press_r);
      5: return scaled(fscale_r);
      6: return temp_r;
      7: return {8'h00, batt_r};
      8: return pcoef_r;
      9: return tcoef_r;
      int'(REG_CCOEF): return ccoef_r;
      default: return loop_r;
    endcase
  endfunction

  function automatic int try_frame(output logic [7:0] rsp[$], output bit bflag);
    int cnt, flen, rg, num;
    logic [7:0] f;
    logic [15:0] c;
    rsp = {};
    bflag = 0;
    cnt = rx_q.size();
    if (cnt < 2) return 0;
    if (rx_q[0] != addr_r && rx_q[0] != BCAST_ADDR) return 1;
    f = rx_q[1];
    if (f != FC_READ && f != FC_WRITE && f != FC_WRMULTI) return 1;
    if (cnt < FRAME_SHORT) return 0;
    if (f == FC_WRMULTI) begin
      if (rx_q[6] != SERIAL_BYTES) return 1;
      if (cnt < FRAME_MAX) return 0;
      flen = FRAME_MAX;
    end else begin
      flen = FRAME_SHORT;
    end
    if ({rx_q[flen-1], rx_q[flen-2]} != frame_crc(rx_q, flen - 2)) return 1;
    rg = {rx_q[2], rx_q[3]};
    num = {rx_q[4], rx_q[5]};
    if (f == FC_READ) begin
      if (rg == int'(REG_SERIAL)) begin
        rsp = {addr_r, FC_READ, 8'd8};
        for (int k = 0; k < 8; k++) rsp.push_back(serial_r[63-8*k -: 8]);
      end else if ((rg < 10 && num + rg < 11) ||
                   (rg >= int'(REG_CCOEF) && rg < 'h32 && num + rg < 'h33)) begin
        rsp = {addr_r, FC_READ, 8'(num * 2)};
        for (int k = 0; k < num; k++) begin
          c = reg_value(rg + k);
          rsp.push_back(c[15:8]);
          rsp.push_back(c[7:0]);
        end
      end else begin
        return 1;
      end
    end else if (f == FC_WRITE) begin
      if (rg == int'(REG_ADDR)) begin
        addr_r = rx_q[5];
      end else if (rg == int'(REG_BAUD)) begin
        if (rx_q[5] >= 1 && rx_q[5] <= 4) begin
          baud_r = rx_q[5][2:0];
          bflag = 1;
        end
      end else if (rg == int'(REG_PCOEF) || rg == int'(REG_TCOEF) || rg == int'(REG_CCOEF)) begin
        if (num >= int'(COEF_MIN) && num <= int'(COEF_MAX)) begin
          if (rg == int'(REG_PCOEF)) pcoef_r = num[15:0];
          else if (rg == int'(REG_TCOEF)) tcoef_r = num[15:0];
          else ccoef_r = num[15:0];
        end
      end else begin
        return 1;
      end
      rsp = {addr_r, FC_WRITE, rx_q[2], rx_q[3], rx_q[4], rx_q[5]};
    end else begin
      for (int k = 0; k < 8; k++) serial_r = {serial_r[55:0], rx_q[7+k]};
      rsp = {addr_r, FC_WRMULTI, rx_q[2], rx_q[3], rx_q[4], rx_q[5]};
    end
    c = frame_crc(rsp, rsp.size());
    rsp.push_back(c[7:0]);
    rsp.push_back(c[15:8]);
    return flen;
  endfunction

  task automatic scan_buffer();
    int n, d;
    logic [7:0] rsp[$];
    bit bflag;
    tx_beat_t e;
    n = 0;
    forever begin
      if (n + MAX_RESP > MAX_OUT) break;
      d = try_frame(rsp, bflag);
      if (d == 0) break;
      foreach (rsp[k]) begin
        e.tx = rsp[k];
        e.last = (k == rsp.size() - 1);
        e.bchg = bflag;
        e.baud = baud_r;
        resp_q.push_back(e);
        n++;
      end
      if (d > rx_q.size()) d = rx_q.size();
      repeat (d) void'(rx_q.pop_front());
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_r = 8'd1; baud_r = 3'd3; dec_r = 8'd2; unit_r = 8'd0; fscale_r = '0;
      pcoef_r = 16'd10000; tcoef_r = 16'd10000; ccoef_r = 16'd10000;
      serial_r = '0; press_r = '0; temp_r = '0; batt_r = '0; loop_r = '0;
      rx_q = {};
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SLAVE_ADDR: addr_r = cfg_data_i[7:0];
          CFG_BAUD:       baud_r = baud_load(cfg_data_i[2:0]);
          CFG_DECIMAL:    dec_r = cfg_data_i[7:0];
          CFG_UNIT:       unit_r = cfg_data_i[7:0];
          CFG_FULL_SCALE: fscale_r = cfg_data_i;
          CFG_PCOEF:      pcoef_r = cfg_data_i[15:0];
          CFG_TCOEF:      tcoef_r = cfg_data_i[15:0];
          CFG_CCOEF:      ccoef_r = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (resp_q.size() == 0) begin
          $error("unexpected response byte %0h", m_axis_tdata[7:0]);
          fail_count_o++;
        end else begin
          tx_beat_t e;
          e = resp_q.pop_front();
          if (m_axis_tdata[7:0] !== e.tx) begin
            $error("tx_byte expected %0h actual %0h", e.tx, m_axis_tdata[7:0]);
            fail_count_o++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last_of_frame expected %0d actual %0d", e.last, m_axis_tlast);
            fail_count_o++;
          end
          if (m_axis_tuser !== e.bchg) begin
            $error("baud_changed expected %0d actual %0d", e.bchg, m_axis_tuser);
            fail_count_o++;
          end
          if (m_axis_tdata[10:8] !== e.baud) begin
            $error("new_baud_code expected %0d actual %0d", e.baud, m_axis_tdata[10:8]);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (item_kind_e'(s_axis_tuser) == ITEM_BYTE) begin
          if (rx_q.size() < RX_DEPTH) rx_q.push_back(s_axis_tdata[7:0]);
        end else begin
          case (meas_e'(s_axis_tdata[9:8]))
            MEAS_PRESS: press_r = s_axis_tdata[41:10];
            MEAS_TEMP:  temp_r = s_axis_tdata[25:10];
            MEAS_BATT:  batt_r = s_axis_tdata[17:10];
            default:    loop_r = s_axis_tdata[25:10];
          endcase
        end
        scan_buffer();
      end
    end
  end

endmodule

// ===== bench/modbus_rtu_slave_responder_core_tb.sv =====
// Testbench top for the Modbus RTU slave responder core: drives request frames,
// measurement updates and config writes; depends on mrs_pkg and the checker.
`timescale 1ns / 1ps
module modbus_rtu_slave_responder_core_tb;
  import mrs_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          fail_count, pending;

  int          idle_pct = 0, stall_pct = 0, sent = 0;
  bit          hold_req = 0;
  int          hold_left = 0;
  logic [7:0]  cur_addr = 8'd1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  modbus_rtu_slave_responder_core DUT (.*);

  modbus_rtu_slave_responder_core_chk u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_left <= 3000;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #100_000_000;
    $display("modbus_rtu_slave_responder_core verification failed");
    $finish;
  end

  task automatic send_item(input item_kind_e kind, input logic [7:0] b,
                           input meas_e idx, input logic [31:0] val);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {6'b0, val, idx, b};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    sent++;
  endtask

  function automatic void add_crc(ref logic [7:0] q[$]);
    logic [15:0] c;
    c = 16'hFFFF;
    foreach (q[i]) begin
      c = c ^ {8'h00, q[i]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    q.push_back(c[7:0]);
    q.push_back(c[15:8]);
  endfunction

  task automatic send_frame(input logic [7:0] q[$]);
    foreach (q[i]) send_item(ITEM_BYTE, q[i], MEAS_PRESS, $urandom);
  endtask

  task automatic send_req(input logic [7:0] fc, input logic [15:0] rg,
                          input logic [15:0] num, input bit bad_crc);
    logic [7:0] q[$];
    logic [7:0] dst;
    dst = ($urandom_range(4) == 0) ? BCAST_ADDR : cur_addr;
    q = {dst, fc, rg[15:8], rg[7:0], num[15:8], num[7:0]};
    add_crc(q);
    if (bad_crc) q[7] = q[7] ^ 8'(1 << $urandom_range(7));
    else if (fc == FC_WRITE && rg == REG_ADDR) cur_addr = num[7:0];
    send_frame(q);
  endtask

  task automatic send_serial(input logic [63:0] sn);
    logic [7:0] q[$];
    q = {cur_addr, FC_WRMULTI, 8'h00, 8'h40, 8'h00, 8'h04, SERIAL_BYTES};
    for (int k = 0; k < 8; k++) q.push_back(sn[63-8*k -: 8]);
    add_crc(q);
    send_frame(q);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_SLAVE_ADDR) cur_addr = val[7:0];
  endtask

  task automatic cfg_all(input logic [7:0] a, input logic [2:0] bd, input logic [7:0] dp,
                         input logic [7:0] un, input logic [31:0] fs, input logic [15:0] pc,
                         input logic [15:0] tc, input logic [15:0] cc);
    cfg_write(CFG_SLAVE_ADDR, {24'($urandom), a});
    cfg_write(CFG_BAUD, {29'($urandom), bd});
    cfg_write(CFG_DECIMAL, {24'($urandom), dp});
    cfg_write(CFG_UNIT, {24'($urandom), un});
    cfg_write(CFG_FULL_SCALE, fs);
    cfg_write(CFG_PCOEF, {16'($urandom), pc});
    cfg_write(CFG_TCOEF, {16'($urandom), tc});
    cfg_write(CFG_CCOEF, {16'($urandom), cc});
  endtask

  task automatic random_traffic(input int n_items);
    int stop, sel;
    logic [15:0] rg;
    stop = sent + n_items;
    while (sent < stop) begin
      sel = $urandom_range(99);
      if (sel < 10) begin
        send_item(ITEM_MEAS, 8'($urandom), meas_e'($urandom_range(3)), $urandom);
      end else if (sel < 18) begin
        send_item(ITEM_BYTE, 8'($urandom), MEAS_PRESS, $urandom);
      end else if (sel < 40) begin
        rg = 16'($urandom_range(9));
        send_req(FC_READ, rg, 16'($urandom_range(10 - rg)), $urandom_range(9) == 0);
      end else if (sel < 48) begin
        rg = 16'h30 + 16'($urandom_range(1));
        send_req(FC_READ, rg, 16'($urandom_range(16'h32 - rg)), 1'b0);
      end else if (sel < 53) begin
        send_req(FC_READ, REG_SERIAL, 16'($urandom), 1'b0);
      end else if (sel < 58) begin
        send_req(FC_READ, 16'($urandom), 16'($urandom), 1'b0);
      end else if (sel < 64) begin
        send_req(FC_WRITE, REG_ADDR, {8'($urandom), 8'($urandom_range(1, 255))}, 1'b0);
      end else if (sel < 72) begin
        send_req(FC_WRITE, REG_BAUD, {8'($urandom), 8'($urandom_range(7))}, 1'b0);
      end else if (sel < 84) begin
        case ($urandom_range(2))
          0: rg = REG_PCOEF;
          1: rg = REG_TCOEF;
          default: rg = REG_CCOEF;
        endcase
        send_req(FC_WRITE, rg, ($urandom_range(1) ? 16'($urandom_range(6000, 14000))
                                                  : 16'($urandom)), $urandom_range(9) == 0);
      end else if (sel < 88) begin
        send_req(FC_WRITE, 16'($urandom), 16'($urandom), 1'b0);
      end else if (sel < 94) begin
        send_serial({$urandom, $urandom});
      end else begin
        send_req(8'($urandom), 16'($urandom), 16'($urandom), 1'b0);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(ITEM_MEAS, 8'h00, MEAS_PRESS, 32'h8000_0000);
    send_item(ITEM_MEAS, 8'hFF, MEAS_TEMP, 32'h7FFF_FFFF);
    send_item(ITEM_MEAS, 8'h00, MEAS_BATT, 32'hFFFF_FFFF);
    send_item(ITEM_MEAS, 8'hFF, MEAS_LOOP, 32'h0001_2345);
    send_req(FC_READ, 16'd0, 16'd10, 1'b0);
    send_req(FC_READ, 16'd4, 16'd0, 1'b0);
    send_req(FC_READ, 16'h30, 16'd2, 1'b0);
    send_req(FC_READ, 16'd5, 16'd6, 1'b0);
    send_req(FC_READ, REG_SERIAL, 16'hFFFF, 1'b0);
    send_serial(64'hFEDC_BA98_7654_3210);
    send_req(FC_READ, REG_SERIAL, 16'd1, 1'b0);
    send_req(FC_WRITE, REG_BAUD, 16'd4, 1'b0);
    send_req(FC_WRITE, REG_BAUD, 16'd5, 1'b0);
    send_req(FC_WRITE, REG_PCOEF, COEF_MIN, 1'b0);
    send_req(FC_WRITE, REG_TCOEF, COEF_MAX, 1'b0);
    send_req(FC_WRITE, REG_CCOEF, 16'd6999, 1'b0);
    send_req(FC_WRITE, REG_CCOEF, 16'd13001, 1'b0);
    send_req(FC_WRITE, 16'd2, 16'd1, 1'b0);
    send_req(FC_READ, 16'd0, 16'd2, 1'b1);
    send_req(8'd4, 16'd0, 16'd1, 1'b0);
    send_req(FC_WRITE, REG_ADDR, 16'h00F7, 1'b0);
    send_req(FC_READ, 16'd0, 16'd1, 1'b0);
    drain();

    cfg_all(8'd255, 3'd4, 8'd0, 8'd255, 32'h8000_0000, 16'd0, 16'd0, 16'd0);
    random_traffic(50);
    drain();

    idle_pct = 65;
    cfg_all(8'd0, 3'd0, 8'd255, 8'd0, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_traffic(50);
    drain();

    idle_pct = 0;
    stall_pct = 65;
    cfg_all(8'($urandom), 3'($urandom_range(7)), 8'($urandom), 8'($urandom), $urandom,
            16'($urandom), 16'($urandom), 16'($urandom));
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    random_traffic(50);
    drain();

    idle_pct = 19;
    stall_pct = 19;
    cfg_all(8'd1, 3'd1, 8'd2, 8'($urandom), -32'sd12345, 16'd10000, 16'd7000, 16'd13000);
    random_traffic(50);
    drain();

    if (fail_count == 0) begin
      $display("modbus_rtu_slave_responder_core verification clean");
    end else begin
      $display("modbus_rtu_slave_responder_core verification failed");
    end
    $finish;
  end

endmodule
